// File: src/lps_pkg.sv
package lps_pkg;

  localparam int unsigned CntW   = 13;
  localparam int unsigned FrameW = 5;
  localparam int unsigned PatW   = 2;
  localparam int unsigned LedW   = 8;

  localparam logic [CntW-1:0] MinPeriod   = CntW'(1500);
  localparam logic [CntW-1:0] MaxPeriod   = CntW'(5000);
  localparam logic [CntW-1:0] StartPeriod = CntW'(2000);
  localparam logic [CntW-1:0] PeriodStep  = CntW'(100);
  localparam logic [CntW-1:0] CountMax    = {CntW{1'b1}};

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_FASTER = 2'd1,
    KEY_SLOWER = 2'd2,
    KEY_STOP   = 2'd3
  } key_e;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_START = 1'b1
  } func_e;

  typedef enum logic [PatW-1:0] {
    PAT_BOUNCE   = 2'd0,
    PAT_CROSS    = 2'd1,
    PAT_BILLIARD = 2'd2,
    PAT_TENNIS   = 2'd3
  } pat_e;

  typedef struct packed {
    logic              run;
    logic [FrameW-1:0] frame;
    logic [CntW-1:0]   count;
  } lps_state_t;

  // Number of frames in one pass of each pattern.
  function automatic logic [FrameW:0] lps_pat_len(input logic [PatW-1:0] pat);
    logic [FrameW:0] len;
    unique case (pat)
      PAT_BOUNCE:   len = (FrameW+1)'(14);
      PAT_CROSS:    len = (FrameW+1)'(7);
      PAT_BILLIARD: len = (FrameW+1)'(23);
      default:      len = (FrameW+1)'(12);
    endcase
    return len;
  endfunction

endpackage

// File: src/lps_if.sv
interface lps_in_if;
  import lps_pkg::*;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic            valid;
  logic            ready;
  logic [LedW-1:0] leds;
  logic            running;
  logic [CntW-1:0] period_now;

  modport source (output valid, output leds, output running, output period_now,
                  input ready);
  modport sink   (input valid, input leds, input running, input period_now,
                  output ready);
endinterface

// File: src/led_pattern_sequencer.sv
// An accepted input item waits in the input register; its result is written to the
// result register once that register is free or being taken, and is valid from then on.
// Throughput: one item per cycle while the result is not stalled; the dwell counter, frame index
// and period table entry update together, with an input and a result register.
// A stalled result holds the input register; the input side keeps flowing otherwise.
// Reset is asynchronous and active low: stopped, frame 0, count 0, pattern 0,
// all stored periods 2000.
module led_pattern_sequencer
  import lps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PatW-1:0]  cfg_wdata_i,
  lps_in_if.sink           in_i,
  lps_out_if.source        out_o
);

  logic [PatW-1:0] pat_q;
  logic [CntW-1:0] period_q [4];
  lps_state_t      state_q, state_d;
  logic [CntW-1:0] period_d;

  logic            s1_valid_q;
  logic            func_q;
  logic [1:0]      key_q;

  logic            out_valid_q;
  logic [LedW-1:0] leds_q;
  logic            running_q;
  logic [CntW-1:0] period_now_q;

  logic            advance;
  logic [LedW-1:0] frame_leds;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= PAT_BOUNCE;
    end else if (cfg_we_i) begin
      pat_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      func_q <= in_i.func;
      key_q  <= in_i.key;
    end
  end

  lps_step u_step (
    .func_i   (func_q),
    .key_i    (key_q),
    .pat_i    (pat_q),
    .state_i  (state_q),
    .period_i (period_q[pat_q]),
    .state_o  (state_d),
    .period_o (period_d)
  );

  lps_frame_rom u_rom (
    .pat_i  (pat_q),
    .idx_i  (state_d.frame),
    .leds_o (frame_leds)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      for (int i = 0; i < 4; i++) begin
        period_q[i] <= StartPeriod;
      end
    end else if (advance) begin
      state_q         <= state_d;
      period_q[pat_q] <= period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      leds_q       <= state_d.run ? frame_leds : '0;
      running_q    <= state_d.run;
      period_now_q <= period_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.leds       = leds_q;
  assign out_o.running    = running_q;
  assign out_o.period_now = period_now_q;

  // A stopped sequence shows a dark row.
  a_dark_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !running_q |-> leds_q == '0)
    else $error("leds lit while stopped");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> period_now_q >= MinPeriod && period_now_q <= MaxPeriod)
    else $error("stored period out of range");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, state_q.frame} < lps_pat_len(PAT_BILLIARD))
    else $error("frame index beyond longest pattern");

  // An item waiting behind a stalled result is neither lost nor changed.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(func_q) && $stable(key_q))
    else $error("input item dropped while stalled");

endmodule

// File: src/lps_frame_rom.sv
module lps_frame_rom
  import lps_pkg::*;
(
  input  logic [PatW-1:0]   pat_i,
  input  logic [FrameW-1:0] idx_i,
  output logic [LedW-1:0]   leds_o
);

  logic [FrameW-1:0] idx_sel;
  logic [3:0]        back_shift;

  // An index beyond the end of the selected pattern shows its first frame.
  assign idx_sel    = ({1'b0, idx_i} < lps_pat_len(pat_i)) ? idx_i : '0;
  assign back_shift = 4'd14 - idx_sel[3:0];

  always_comb begin
    leds_o = '0;
    unique case (pat_i)
      PAT_BOUNCE: begin
        // Light walks up to the left end, then back down to bit 1.
        if (idx_sel <= FrameW'(7)) begin
          leds_o = LedW'(1) << idx_sel[2:0];
        end else begin
          leds_o = LedW'(1) << back_shift[2:0];
        end
      end
      PAT_CROSS: begin
        unique case (idx_sel)
          5'd0:    leds_o = 8'h81;
          5'd1:    leds_o = 8'h42;
          5'd2:    leds_o = 8'h24;
          5'd3:    leds_o = 8'h18;
          5'd4:    leds_o = 8'h18;
          5'd5:    leds_o = 8'h24;
          default: leds_o = 8'h42;
        endcase
      end
      PAT_BILLIARD: begin
        unique case (idx_sel)
          5'd0:    leds_o = 8'h08;
          5'd1:    leds_o = 8'h09;
          5'd2:    leds_o = 8'h09;
          5'd3:    leds_o = 8'h0B;
          5'd4:    leds_o = 8'h0B;
          5'd5:    leds_o = 8'h09;
          5'd6:    leds_o = 8'h09;
          5'd7:    leds_o = 8'h08;
          5'd8:    leds_o = 8'h08;
          5'd9:    leds_o = 8'h09;
          5'd10:   leds_o = 8'h09;
          5'd11:   leds_o = 8'h0B;
          5'd12:   leds_o = 8'h0B;
          5'd13:   leds_o = 8'h09;
          5'd14:   leds_o = 8'h08;
          5'd15:   leds_o = 8'h09;
          5'd16:   leds_o = 8'h0B;
          5'd17:   leds_o = 8'h0F;
          5'd18:   leds_o = 8'h17;
          5'd19:   leds_o = 8'h23;
          5'd20:   leds_o = 8'h41;
          5'd21:   leds_o = 8'h80;
          default: leds_o = 8'h00;
        endcase
      end
      default: begin
        unique case (idx_sel)
          5'd0:    leds_o = 8'h85;
          5'd1:    leds_o = 8'h86;
          5'd2:    leds_o = 8'h89;
          5'd3:    leds_o = 8'h89;
          5'd4:    leds_o = 8'h91;
          5'd5:    leds_o = 8'h91;
          5'd6:    leds_o = 8'hA1;
          5'd7:    leds_o = 8'h61;
          5'd8:    leds_o = 8'h91;
          5'd9:    leds_o = 8'h91;
          5'd10:   leds_o = 8'h89;
          default: leds_o = 8'h89;
        endcase
      end
    endcase
  end

endmodule

// File: src/lps_step.sv
module lps_step
  import lps_pkg::*;
(
  input  logic            func_i,
  input  logic [1:0]      key_i,
  input  logic [PatW-1:0] pat_i,
  input  lps_state_t      state_i,
  input  logic [CntW-1:0] period_i,
  output lps_state_t      state_o,
  output logic [CntW-1:0] period_o
);

  logic [CntW-1:0] cnt_dec;
  logic [CntW-1:0] cnt_key;
  logic [CntW:0]   cnt_sum;
  logic [CntW-1:0] p_key;
  logic [FrameW:0] frame_inc;
  logic            stop;

  assign cnt_dec   = (state_i.count != '0) ? state_i.count - CntW'(1) : '0;
  assign cnt_sum   = {1'b0, cnt_dec} + {1'b0, PeriodStep};
  assign frame_inc = {1'b0, state_i.frame} + (FrameW+1)'(1);

  always_comb begin
    p_key   = period_i;
    cnt_key = cnt_dec;
    stop    = 1'b0;
    unique case (key_e'(key_i))
      KEY_FASTER: begin
        if (period_i > MinPeriod) begin
          p_key = (period_i - MinPeriod > PeriodStep) ? period_i - PeriodStep : MinPeriod;
        end
        if (cnt_dec > MinPeriod) begin
          cnt_key = (cnt_dec > PeriodStep) ? cnt_dec - PeriodStep : '0;
        end
      end
      KEY_SLOWER: begin
        if (period_i < MaxPeriod) begin
          p_key = (MaxPeriod - period_i > PeriodStep) ? period_i + PeriodStep : MaxPeriod;
        end
        if (cnt_dec < MaxPeriod) begin
          cnt_key = (cnt_sum > {1'b0, CountMax}) ? CountMax : cnt_sum[CntW-1:0];
        end
      end
      KEY_STOP: begin
        stop = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_o  = state_i;
    period_o = period_i;
    if (func_e'(func_i) == FUNC_START) begin
      state_o.run   = 1'b1;
      state_o.frame = '0;
      state_o.count = period_i;
    end else if (state_i.run) begin
      period_o      = p_key;
      state_o.count = cnt_key;
      if (stop) begin
        state_o.run = 1'b0;
      end else if (cnt_key == '0) begin
        // Dwell over: step to the next frame and reload from the new period.
        state_o.frame = (frame_inc >= lps_pat_len(pat_i)) ? '0 : frame_inc[FrameW-1:0];
        state_o.count = p_key;
      end
    end
  end

endmodule
